>>> hdl/lfhtc_pkg.sv
// Package for the push/pop trace checker: widths, verdict codes, command
// and status structs. Depends on nothing.
`default_nettype none
package lfhtc_pkg;
  localparam int DEPTH_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 16;
  localparam int IN_VALUE_W     = 16;
  localparam int VERDICT_W      = 3;

  localparam logic [VERDICT_W-1:0] VERDICT_UNSURE     = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_IMPOSSIBLE = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_STACK      = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_QUEUE      = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_HEAP       = 3'd4;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;      // latch item, do stack and fifo work, start heap op
    logic heap_rd;    // issue heap memory read for current step
    logic heap_step;  // evaluate one heap level with read data
    logic finish;     // compute result fields and load output register
  } lfhtc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic heap_busy;  // heap operation still has levels to walk
  } lfhtc_sts_t;

  // Verdict from the three consistency flags.
  function automatic logic [VERDICT_W-1:0] verdict_of(input logic s, input logic f,
                                                     input logic h);
    logic [1:0] n;
    n = {1'b0, s} + {1'b0, f} + {1'b0, h};
    if (n > 2'd1)      verdict_of = VERDICT_UNSURE;
    else if (n == 2'd0) verdict_of = VERDICT_IMPOSSIBLE;
    else if (s)        verdict_of = VERDICT_STACK;
    else if (f)        verdict_of = VERDICT_QUEUE;
    else               verdict_of = VERDICT_HEAP;
  endfunction
endpackage
`default_nettype wire

>>> hdl/lfhtc_if.sv
// Valid/ready channel interfaces for the trace checker.
// Depends on lfhtc_pkg.
`default_nettype none
interface lfhtc_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [lfhtc_pkg::IN_VALUE_W-1:0]   value;
  logic                               last;
  modport source (output valid, mode, value, last, input ready);
  modport sink   (input valid, mode, value, last, output ready);
endinterface

interface lfhtc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              stack_ok;
  logic                              fifo_ok;
  logic                              heap_ok;
  logic [lfhtc_pkg::VERDICT_W-1:0]   verdict;
  logic                              overflow;
  modport source (output valid, stack_ok, fifo_ok, heap_ok, verdict, overflow,
                  input ready);
  modport sink   (input valid, stack_ok, fifo_ok, heap_ok, verdict, overflow,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/lfhtc_ctrl.sv
// Controller state machine for the trace checker.
// Depends on lfhtc_pkg.
`default_nettype none
module lfhtc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_fire,
  input  wire logic                  out_busy,
  input  wire lfhtc_pkg::lfhtc_sts_t sts,
  output logic                       in_ready,
  output lfhtc_pkg::lfhtc_cmd_t      cmd
);
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state: item -> read/eval per heap level -> result.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.start = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (sts.heap_busy) begin
          cmd.heap_rd = 1'b1;
          state_nxt   = ST_EVAL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_EVAL: begin
        cmd.heap_step = 1'b1;
        state_nxt     = ST_RD;
      end
      ST_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end
endmodule
`default_nettype wire

>>> hdl/lfhtc_dp.sv
// Datapath for the trace checker: three stores, counters, heap sift unit
// and output register. Depends on lfhtc_pkg.
`default_nettype none
module lfhtc_dp #(
  parameter int DEPTH      = lfhtc_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = lfhtc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_mode,
  input  wire logic [lfhtc_pkg::IN_VALUE_W-1:0] in_value,
  input  wire logic                          in_last,
  input  wire lfhtc_pkg::lfhtc_cmd_t         cmd,
  output lfhtc_pkg::lfhtc_sts_t              sts,
  output logic                               out_busy,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_stack_ok,
  output logic                               out_fifo_ok,
  output logic                               out_heap_ok,
  output logic [lfhtc_pkg::VERDICT_W-1:0]    out_verdict,
  output logic                               out_overflow
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = VALUE_BITS;
  localparam int KW = (VW < lfhtc_pkg::IN_VALUE_W) ? VW : lfhtc_pkg::IN_VALUE_W;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [VW-1:0] stack_mem [DEPTH];
  logic [VW-1:0] fifo_mem  [DEPTH];
  logic [VW-1:0] heap_mem  [DEPTH];

  logic [CW-1:0] stack_cnt_r, fifo_cnt_r, heap_cnt_r;
  logic [AW-1:0] fifo_head_r;
  logic          alive_s_r, alive_f_r, alive_h_r;
  logic          ovf_r, last_r, mode_r, pop_s_r, pop_f_r, pop_h_r;
  logic [VW-1:0] val_r, hv_r;        // observed value, value being sifted
  logic [VW-1:0] s_rd_r, f_rd_r;     // popped stack and fifo values
  logic [VW-1:0] top_r;              // heap root at pop
  logic [CW-1:0] hi_r;               // heap hole index
  logic          hbusy_r;
  logic          hload_r;            // root and last entry arrive this cycle
  logic [VW-1:0] rd_a_r, rd_b_r;     // heap read data (parent, or two children)
  logic          has_b_r;

  logic [VW-1:0] in_val;
  always_comb begin
    in_val = '0;
    in_val[KW-1:0] = in_value[KW-1:0];
  end

  assign sts.heap_busy = hbusy_r;

  // Full checks and the push/pop split of the offered item.
  logic in_push, s_full, f_full, h_full;
  assign in_push = (in_mode == lfhtc_pkg::MODE_PUSH);
  assign s_full  = (stack_cnt_r >= FULL);
  assign f_full  = (fifo_cnt_r >= FULL);
  assign h_full  = (heap_cnt_r >= FULL);

  // Stack and fifo addresses; the fifo tail wraps at DEPTH.
  logic [AW-1:0] s_top, f_tail;
  logic [CW:0]   fsum;
  assign s_top  = AW'(stack_cnt_r - CW'(1));
  assign fsum   = (CW+1)'(fifo_head_r) + (CW+1)'(fifo_cnt_r);
  assign f_tail = (fsum >= (CW+1)'(DEPTH)) ? AW'(fsum - (CW+1)'(DEPTH)) : AW'(fsum);

  // Heap level arithmetic.
  logic [CW:0]   lidx, ridx, hcnt_x;
  logic [CW-1:0] pidx;
  logic          pop_leaf;
  assign lidx     = {hi_r, 1'b0} + (CW+1)'(1);
  assign ridx     = lidx + (CW+1)'(1);
  assign pidx     = (hi_r - CW'(1)) >> 1;
  assign hcnt_x   = (CW+1)'(heap_cnt_r);
  assign pop_leaf = (lidx >= hcnt_x);

  // One heap level: does the hole move, and where to.
  logic          hbig_b, hmove;
  logic [VW-1:0] hbig;
  logic [CW-1:0] hnext;
  always_comb begin
    hbig_b = has_b_r && (rd_b_r > rd_a_r);
    hbig   = hbig_b ? rd_b_r : rd_a_r;
    if (mode_r == lfhtc_pkg::MODE_PUSH) begin
      hmove = (hi_r != '0) && (rd_a_r < hv_r);
      hnext = pidx;
    end else begin
      hmove = !pop_leaf && (hbig > hv_r);
      hnext = hbig_b ? CW'(ridx) : CW'(lidx);
    end
  end

  // Memory ports for the stack and fifo.
  always_ff @(posedge clk) begin
    if (cmd.start && alive_s_r) begin
      if (in_push && stack_cnt_r < FULL)
        stack_mem[stack_cnt_r[AW-1:0]] <= in_val;
      s_rd_r <= stack_mem[s_top];
    end
    if (cmd.start && alive_f_r) begin
      if (in_push && fifo_cnt_r < FULL)
        fifo_mem[f_tail] <= in_val;
      f_rd_r <= fifo_mem[fifo_head_r];
    end
  end

  // Heap memory: one write port, two read ports with registered data. At item
  // start the ports fetch the root and the last entry.
  logic          hwe, hre;
  logic [AW-1:0] hwa;
  logic [VW-1:0] hwd;
  logic [AW-1:0] hra, hrb;
  always_comb begin
    hre = cmd.start || cmd.heap_rd;
    hra = '0;
    hrb = '0;
    if (cmd.start) hrb = AW'(heap_cnt_r - CW'(1));
    else if (mode_r == lfhtc_pkg::MODE_PUSH) hra = pidx[AW-1:0];
    else begin
      hra = lidx[AW-1:0];
      hrb = (ridx < hcnt_x) ? ridx[AW-1:0] : lidx[AW-1:0];
    end
    hwe = cmd.heap_step &&
          (mode_r == lfhtc_pkg::MODE_PUSH || !pop_leaf || heap_cnt_r != '0);
    hwa = hi_r[AW-1:0];
    if (hmove) hwd = (mode_r == lfhtc_pkg::MODE_PUSH) ? rd_a_r : hbig;
    else       hwd = hv_r;
  end

  always_ff @(posedge clk) begin
    if (hwe) heap_mem[hwa] <= hwd;
    if (hre) begin
      rd_a_r <= heap_mem[hra];
      rd_b_r <= heap_mem[hrb];
    end
  end

  // Flags after the pop comparisons.
  logic s_ok, f_ok, h_ok;
  assign s_ok = alive_s_r && !(pop_s_r && s_rd_r != val_r);
  assign f_ok = alive_f_r && !(pop_f_r && f_rd_r != val_r);
  assign h_ok = alive_h_r && !(pop_h_r && top_r != val_r);

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_cnt_r <= '0; fifo_cnt_r <= '0; heap_cnt_r <= '0; fifo_head_r <= '0;
      alive_s_r <= 1'b1; alive_f_r <= 1'b1; alive_h_r <= 1'b1;
      hbusy_r <= 1'b0; out_valid <= 1'b0; ovf_r <= 1'b0; hload_r <= 1'b0;
    end else begin
      if (cmd.finish)                  out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      hload_r <= cmd.start && !in_push && alive_h_r && heap_cnt_r != '0;
      if (cmd.start) begin
        mode_r <= in_mode; val_r <= in_val; last_r <= in_last;
        ovf_r <= in_push && ((alive_s_r && s_full) || (alive_f_r && f_full) ||
                             (alive_h_r && h_full));
        pop_s_r <= !in_push && alive_s_r && stack_cnt_r != '0;
        pop_f_r <= !in_push && alive_f_r && fifo_cnt_r != '0;
        pop_h_r <= !in_push && alive_h_r && heap_cnt_r != '0;
        hbusy_r <= alive_h_r && (in_push ? !h_full : heap_cnt_r != '0);
        if (in_push) begin
          if (alive_s_r) begin
            if (!s_full) stack_cnt_r <= stack_cnt_r + CW'(1);
            else alive_s_r <= 1'b0;
          end
          if (alive_f_r) begin
            if (!f_full) fifo_cnt_r <= fifo_cnt_r + CW'(1);
            else alive_f_r <= 1'b0;
          end
          if (alive_h_r) begin
            if (!h_full) begin
              heap_cnt_r <= heap_cnt_r + CW'(1);
              hi_r <= heap_cnt_r; hv_r <= in_val;
            end else alive_h_r <= 1'b0;
          end
        end else begin
          if (alive_s_r) begin
            if (stack_cnt_r == '0) alive_s_r <= 1'b0;
            else stack_cnt_r <= stack_cnt_r - CW'(1);
          end
          if (alive_f_r) begin
            if (fifo_cnt_r == '0) alive_f_r <= 1'b0;
            else begin
              fifo_cnt_r <= fifo_cnt_r - CW'(1);
              fifo_head_r <= (fifo_head_r == AW'(DEPTH - 1)) ? '0 : fifo_head_r + AW'(1);
            end
          end
          if (alive_h_r) begin
            if (heap_cnt_r == '0) alive_h_r <= 1'b0;
            else begin
              heap_cnt_r <= heap_cnt_r - CW'(1);
              hi_r <= '0;
            end
          end
        end
      end
      // Pop sift-down starts from the root with the moved last entry.
      if (hload_r) begin
        top_r <= rd_a_r;
        hv_r  <= rd_b_r;
      end
      if (cmd.heap_rd) has_b_r <= (ridx < hcnt_x);
      if (cmd.heap_step) begin
        if (hmove) hi_r <= hnext;
        else       hbusy_r <= 1'b0;
      end
      if (cmd.finish) begin
        out_stack_ok <= s_ok;
        out_fifo_ok  <= f_ok;
        out_heap_ok  <= h_ok;
        out_verdict  <= lfhtc_pkg::verdict_of(s_ok, f_ok, h_ok);
        out_overflow <= ovf_r;
        alive_s_r <= last_r || s_ok;
        alive_f_r <= last_r || f_ok;
        alive_h_r <= last_r || h_ok;
        if (last_r) begin
          stack_cnt_r <= '0; fifo_cnt_r <= '0; heap_cnt_r <= '0; fifo_head_r <= '0;
        end
      end
    end
  end

  assign out_busy = out_valid && !out_ready;
endmodule
`default_nettype wire

>>> hdl/lifo_fifo_heap_trace_checker.sv
// Top level of the push/pop trace checker: controller plus datapath.
// Depends on lfhtc_pkg, lfhtc_if, lfhtc_ctrl and lfhtc_dp.
//
//   Channel  Direction  Contents
//   in       sink       mode, value, last
//   out      source     stack_ok, fifo_ok, heap_ok, verdict, overflow
//
// An item walks the heap one level at a time, with one memory read and one
// write per level. At DEPTH 1024 a push walks up to 11 levels and a pop up
// to 10. Reset is synchronous, active low, and clears counts and flags;
// memory contents are not cleared. A result waits in the output register
// while the next item is taken; a stalled result holds the block in its
// final state until taken.
`default_nettype none
module lifo_fifo_heap_trace_checker #(
  parameter int DEPTH      = lfhtc_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = lfhtc_pkg::VALUE_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  lfhtc_in_if.sink  in_ch,
  lfhtc_out_if.source out_ch
);
  lfhtc_pkg::lfhtc_cmd_t cmd;
  lfhtc_pkg::lfhtc_sts_t sts;
  logic out_busy;
  logic in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  lfhtc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_busy(out_busy),
    .sts(sts), .in_ready(in_ch.ready), .cmd(cmd)
  );

  lfhtc_dp #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_mode(in_ch.mode), .in_value(in_ch.value), .in_last(in_ch.last),
    .cmd(cmd), .sts(sts), .out_busy(out_busy), .out_ready(out_ch.ready),
    .out_valid(out_ch.valid), .out_stack_ok(out_ch.stack_ok),
    .out_fifo_ok(out_ch.fifo_ok), .out_heap_ok(out_ch.heap_ok),
    .out_verdict(out_ch.verdict), .out_overflow(out_ch.overflow)
  );

`ifndef ASSERT_OFF
  // Verdict agrees with the flags of the result.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.verdict == lfhtc_pkg::verdict_of(out_ch.stack_ok,
                     out_ch.fifo_ok, out_ch.heap_ok))
    else $error("verdict does not match flags");
  // Only one controller command at a time.
  a_cmd: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("overlapping commands");
  // No item is taken while the heap walk is running.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.heap_busy |-> !in_fire)
    else $error("item accepted during heap walk");
`endif
endmodule
`default_nettype wire

>>> tb/tb_lfhtc_pkg.sv
`timescale 1ns / 100ps
// Testbench package for the trace checker: the trace-op and expected-result structs.
// Depends on nothing.
package tb_lfhtc_pkg;
  typedef struct packed {
    logic       mode;
    logic [15:0] value;
    logic       last;
  } trace_op_t;

  typedef struct packed {
    logic       stack_ok;
    logic       fifo_ok;
    logic       heap_ok;
    logic [2:0] verdict;
    logic       overflow;
  } conform_res_t;
endpackage

>>> tb/tb_lifo_fifo_heap_trace_checker.sv
`timescale 1ns / 100ps
// Testbench for the push/pop trace checker: random and directed traces,
// predicted by a behavioral stack/fifo/heap model. Depends on lfhtc_pkg,
// lfhtc_if, tb_lfhtc_pkg and the block.
module tb_lifo_fifo_heap_trace_checker;
  localparam int DEPTH = 1024;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lfhtc_in_if  in_ch ();
  lfhtc_out_if out_ch ();

  lifo_fifo_heap_trace_checker u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state.
  logic [15:0] stk_q[$];
  logic [15:0] fifo_q[$];
  logic [15:0] heap_a[$];
  logic        live_s, live_f, live_h;

  tb_lfhtc_pkg::trace_op_t    pending_ops[$];
  tb_lfhtc_pkg::conform_res_t expected_res[$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           mismatches = 0;

  // Max of the heap contents, removed.
  function automatic logic [15:0] heap_pop_max();
    int best;
    logic [15:0] v;
    best = 0;
    foreach (heap_a[i]) if (heap_a[i] > heap_a[best]) best = i;
    v = heap_a[best];
    heap_a.delete(best);
    return v;
  endfunction

  function automatic void clear_trace();
    stk_q.delete();
    fifo_q.delete();
    heap_a.delete();
    live_s = 1'b1;
    live_f = 1'b1;
    live_h = 1'b1;
  endfunction

  function automatic tb_lfhtc_pkg::conform_res_t predict_conformance(
      tb_lfhtc_pkg::trace_op_t op);
    tb_lfhtc_pkg::conform_res_t r;
    int n;
    r.overflow = 1'b0;
    if (op.mode == lfhtc_pkg::MODE_PUSH) begin
      if (live_s) begin
        if (stk_q.size() >= DEPTH) begin r.overflow = 1'b1; live_s = 1'b0; end
        else stk_q.push_back(op.value);
      end
      if (live_f) begin
        if (fifo_q.size() >= DEPTH) begin r.overflow = 1'b1; live_f = 1'b0; end
        else fifo_q.push_back(op.value);
      end
      if (live_h) begin
        if (heap_a.size() >= DEPTH) begin r.overflow = 1'b1; live_h = 1'b0; end
        else heap_a.push_back(op.value);
      end
    end else begin
      if (live_s) begin
        if (stk_q.size() == 0) live_s = 1'b0;
        else if (stk_q.pop_back() != op.value) live_s = 1'b0;
      end
      if (live_f) begin
        if (fifo_q.size() == 0) live_f = 1'b0;
        else if (fifo_q.pop_front() != op.value) live_f = 1'b0;
      end
      if (live_h) begin
        if (heap_a.size() == 0) live_h = 1'b0;
        else if (heap_pop_max() != op.value) live_h = 1'b0;
      end
    end
    n = int'(live_s) + int'(live_f) + int'(live_h);
    if (n > 1) r.verdict = lfhtc_pkg::VERDICT_UNSURE;
    else if (n == 0) r.verdict = lfhtc_pkg::VERDICT_IMPOSSIBLE;
    else if (live_s) r.verdict = lfhtc_pkg::VERDICT_STACK;
    else if (live_f) r.verdict = lfhtc_pkg::VERDICT_QUEUE;
    else r.verdict = lfhtc_pkg::VERDICT_HEAP;
    r.stack_ok = live_s;
    r.fifo_ok = live_f;
    r.heap_ok = live_h;
    if (op.last) clear_trace();
    return r;
  endfunction

  // Driver: offers items from the pending queue, predicting each one accepted.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.value = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_res.push_back(predict_conformance(pending_ops.pop_front()));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.mode  <= pending_ops[0].mode;
          in_ch.value <= pending_ops[0].value;
          in_ch.last  <= pending_ops[0].last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    tb_lfhtc_pkg::conform_res_t got;
    tb_lfhtc_pkg::conform_res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.stack_ok, out_ch.fifo_ok, out_ch.heap_ok, out_ch.verdict,
              out_ch.overflow};
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        exp_r = expected_res.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_r, got);
        end
      end
    end
  end

  task automatic add_op(input logic m, input logic [15:0] v, input logic l);
    tb_lfhtc_pkg::trace_op_t op;
    op.mode = m;
    op.value = v;
    op.last = l;
    pending_ops.push_back(op);
  endtask

  // Well-formed trace of one kind with random content, optionally broken.
  task automatic add_trace(input int kind, input int len);
    logic [15:0] model[$];
    int best;
    logic [15:0] v;
    for (int i = 0; i < len; i++) begin
      if (model.size() > 0 && ($urandom_range(2) == 0 || i >= len - model.size())) begin
        if (kind == 0) v = model.pop_back();
        else if (kind == 1) v = model.pop_front();
        else begin
          best = 0;
          foreach (model[j]) if (model[j] > model[best]) best = j;
          v = model[best];
          model.delete(best);
        end
        if ($urandom_range(19) == 0) v = 16'($urandom);
        add_op(lfhtc_pkg::MODE_POP, v, i == len - 1);
      end else begin
        v = ($urandom_range(1) == 0) ? 16'($urandom_range(7)) : 16'($urandom);
        model.push_back(v);
        add_op(lfhtc_pkg::MODE_PUSH, v, i == len - 1);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || expected_res.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    clear_trace();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, pop from empty, all verdicts.
    add_op(lfhtc_pkg::MODE_POP, 16'h0000, 1'b1);
    add_op(lfhtc_pkg::MODE_PUSH, 16'hFFFF, 1'b0);
    add_op(lfhtc_pkg::MODE_PUSH, 16'h0000, 1'b0);
    add_op(lfhtc_pkg::MODE_POP, 16'h0000, 1'b0);
    add_op(lfhtc_pkg::MODE_POP, 16'hFFFF, 1'b1);
    add_op(lfhtc_pkg::MODE_PUSH, 16'h0001, 1'b0);
    add_op(lfhtc_pkg::MODE_PUSH, 16'h0005, 1'b0);
    add_op(lfhtc_pkg::MODE_POP, 16'h0001, 1'b1);
    add_op(lfhtc_pkg::MODE_PUSH, 16'h0001, 1'b0);
    add_op(lfhtc_pkg::MODE_PUSH, 16'h0005, 1'b0);
    add_op(lfhtc_pkg::MODE_PUSH, 16'h0003, 1'b0);
    add_op(lfhtc_pkg::MODE_POP, 16'h0005, 1'b0);
    add_op(lfhtc_pkg::MODE_POP, 16'h0003, 1'b1);
    add_op(lfhtc_pkg::MODE_PUSH, 16'hAAAA, 1'b0);
    add_op(lfhtc_pkg::MODE_POP, 16'h5555, 1'b0);
    add_op(lfhtc_pkg::MODE_POP, 16'h5555, 1'b1);
    wait_drained();

    // Overflow: fill every store then push once more.
    for (int i = 0; i < DEPTH; i++) add_op(lfhtc_pkg::MODE_PUSH, 16'($urandom), 1'b0);
    add_op(lfhtc_pkg::MODE_PUSH, 16'h1234, 1'b0);
    add_op(lfhtc_pkg::MODE_POP, 16'h1234, 1'b1);
    wait_drained();

    // Random traces across idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 67 : (ph == 3) ? 37 : 0;
      recv_stall_pct = (ph == 2) ? 67 : (ph == 3) ? 37 : 0;
      for (int n = 0; n < 50; ) begin
        int len;
        len = $urandom_range(1, 16);
        if ($urandom_range(9) == 0) begin
          for (int k = 0; k < len; k++)
            add_op(1'($urandom_range(1)), 16'($urandom), k == len - 1);
        end else begin
          add_trace($urandom_range(2), len);
        end
        n += len;
      end
      wait_drained();
    end
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
